>>> hw/rtl/most_frequent_value_finder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the most frequent value finder
// Shared helpers for writing clocked assertions under the block's reset.
// ----------------------------------------------------------------------------
`ifndef MOST_FREQUENT_VALUE_FINDER_UNIT_MACROS_SVH
`define MOST_FREQUENT_VALUE_FINDER_UNIT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define MFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define MFV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/mfv_pkg.sv
// ----------------------------------------------------------------------------
// Most frequent value finder package
// Sizes, the cell record and the control record shared by the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mfv_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VAL_W     = 32;
  // Wide enough to hold MAX_ITEMS itself.
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic        [CNT_W-1:0] count;
  } cell_t;

  typedef struct packed {
    logic                    ins;     // insert the broadcast sample this cycle
    logic                    scan;    // shift the chain towards the head
    logic                    hit;     // some cell already holds the sample
    logic signed [VAL_W-1:0] sample;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/mfv_if.sv
// ----------------------------------------------------------------------------
// Most frequent value finder channels
// Valid/ready channels for the sample input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfv_sample_if;
  import mfv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sample_value;
  logic                    is_last;

  modport source (output valid, output sample_value, output is_last, input ready);
  modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

interface mfv_result_if;
  import mfv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] mode_value;
  logic        [CNT_W-1:0] mode_count;
  logic                    overflow;

  modport source (output valid, output mode_value, output mode_count, output overflow,
                  input ready);
  modport sink   (input valid, input mode_value, input mode_count, input overflow,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mfv_cell.sv
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one distinct value and its repeat count; inserts, counts or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module mfv_cell
  import mfv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire cell_t      prev_i,
  input  wire logic       prev_gt_i,
  input  wire cell_t      next_i,
  output      cell_t      cell_o,
  output      logic       gt_o,
  output      logic       eq_o
);

  cell_t cell_q, cell_d;

  // Empty cells sit at the tail, so they always count as greater.
  assign gt_o = !cell_q.valid || (ctrl_i.sample < cell_q.value);
  assign eq_o = cell_q.valid && (ctrl_i.sample == cell_q.value);

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.scan) begin
      cell_d = next_i;
    end else if (ctrl_i.ins) begin
      if (eq_o) begin
        cell_d.count = cell_q.count + CNT_W'(1);
      end else if (!ctrl_i.hit && gt_o) begin
        if (prev_gt_i) begin
          cell_d = prev_i;
        end else begin
          // First cell whose value exceeds the sample: the new entry lands here.
          cell_d.valid = 1'b1;
          cell_d.value = ctrl_i.sample;
          cell_d.count = CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

>>> hw/rtl/mfv_best.sv
// ----------------------------------------------------------------------------
// Best entry tracker
// Watches the head of the chain during the scan and keeps the leading entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mfv_best
  import mfv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clear_i,
  input  wire logic                    scan_i,
  input  wire cell_t                   head_i,
  output      logic signed [VAL_W-1:0] best_value_o,
  output      logic        [CNT_W-1:0] best_count_o
);

  logic signed [VAL_W-1:0] best_value_q, best_value_d;
  logic        [CNT_W-1:0] best_count_q, best_count_d;

  // Entries arrive in ascending order, so a strict compare keeps the smallest on a tie.
  always_comb begin
    best_value_d = best_value_q;
    best_count_d = best_count_q;
    if (clear_i) begin
      best_count_d = '0;
    end else if (scan_i && head_i.valid && (head_i.count > best_count_q)) begin
      best_value_d = head_i.value;
      best_count_d = head_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_count_q <= '0;
    end else begin
      best_count_q <= best_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_value_q <= best_value_d;
  end

  assign best_value_o = best_value_q;
  assign best_count_o = best_count_q;

endmodule

`default_nettype wire

>>> hw/rtl/most_frequent_value_finder_unit.sv
// ----------------------------------------------------------------------------
// Most frequent value finder
// Sorts incoming samples into a chain of cells and reports the mode at the end.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                              Beat
//  sample_i  in   sample_value, is_last                one sample of a sequence
//  result_o  out  mode_value, mode_count, overflow     one result per sequence
//
//  Samples are taken one per cycle; every cell compares against the broadcast
//  sample and inserts, counts or shifts in that same cycle.
//  After the last beat the chain drains towards the head, one entry per cycle,
//  and the result is registered once the head cell is empty; the sample
//  input is held off for that whole drain. Reset empties every cell at once.
//  A stalled result holds; a further sequence may load meanwhile, but its drain
//  cannot finish, and the input stays held off, until the earlier result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "most_frequent_value_finder_unit_macros.svh"

module most_frequent_value_finder_unit
  import mfv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mfv_sample_if.sink   sample_i,
  mfv_result_if.source result_o
);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] items_q, items_d;
  logic             ovf_q, ovf_d;
  logic             seq_ovf_q, seq_ovf_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_value_q, out_value_d;
  logic        [CNT_W-1:0] out_count_q, out_count_d;
  logic                    out_ovf_q, out_ovf_d;

  cell_ctrl_t             ctrl;
  cell_t                  cells [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]   gt_vec;
  logic [MAX_ITEMS-1:0]   eq_vec;

  logic                    in_acc;
  logic                    store_full;
  logic                    scan_done;
  logic signed [VAL_W-1:0] best_value;
  logic        [CNT_W-1:0] best_count;

  assign sample_i.ready = (state_q == ST_LOAD);
  assign in_acc         = sample_i.valid && sample_i.ready;
  assign store_full     = (items_q == CNT_W'(MAX_ITEMS));

  assign ctrl.ins    = in_acc && !store_full;
  assign ctrl.scan   = (state_q == ST_SCAN);
  assign ctrl.hit    = |eq_vec;
  assign ctrl.sample = sample_i.sample_value;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_t prev_c;
    cell_t next_c;
    logic  prev_gt;

    if (i == 0) begin : g_head
      assign prev_c  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign prev_c  = cells[i-1];
      assign prev_gt = gt_vec[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end

    mfv_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_i    (prev_c),
      .prev_gt_i (prev_gt),
      .next_i    (next_c),
      .cell_o    (cells[i]),
      .gt_o      (gt_vec[i]),
      .eq_o      (eq_vec[i])
    );
  end

  mfv_best u_best (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (in_acc && sample_i.is_last),
    .scan_i       (ctrl.scan),
    .head_i       (cells[0]),
    .best_value_o (best_value),
    .best_count_o (best_count)
  );

  assign scan_done = (state_q == ST_SCAN) && !cells[0].valid && !out_valid_q;

  always_comb begin
    state_d     = state_q;
    items_d     = items_q;
    ovf_d       = ovf_q;
    seq_ovf_d   = seq_ovf_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_count_d = out_count_q;
    out_ovf_d   = out_ovf_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            items_d = items_q + CNT_W'(1);
          end
          if (sample_i.is_last) begin
            seq_ovf_d = ovf_q || store_full;
            items_d   = '0;
            ovf_d     = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          out_valid_d = 1'b1;
          out_value_d = best_value;
          out_count_d = best_count;
          out_ovf_d   = seq_ovf_q;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      items_q     <= '0;
      ovf_q       <= 1'b0;
      seq_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      items_q     <= items_d;
      ovf_q       <= ovf_d;
      seq_ovf_q   <= seq_ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_count_q <= out_count_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.mode_value = out_value_q;
  assign result_o.mode_count = out_count_q;
  assign result_o.overflow   = out_ovf_q;

  // The loaded item count never passes the store depth.
  `MFV_ASSERT_NEVER(a_items_bound, items_q > CNT_W'(MAX_ITEMS), "item count beyond depth")

  // The first two cells stay packed at the head and strictly ascending.
  `MFV_ASSERT(a_chain_sorted, cells[1].valid |-> (cells[0].valid && (cells[0].value < cells[1].value)), "chain out of order")

  // A finished sequence always leaves at least one entry for the scan.
  `MFV_ASSERT(a_scan_nonempty, (in_acc && sample_i.is_last) |=> cells[0].valid, "scan started on an empty chain")

endmodule

`default_nettype wire

>>> tb/sv/most_frequent_value_finder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Most frequent value finder testbench
// Streams sample sequences through the unit under random back-pressure and
// checks every reported mode, count and overflow flag against a sorted tally
// kept alongside the stimulus.
// ----------------------------------------------------------------------------

module most_frequent_value_finder_unit_tb;
  import mfv_pkg::*;

  typedef logic signed [VAL_W-1:0] sample_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic        [CNT_W-1:0] count;
    logic                    overflow;
  } mode_result_t;

  localparam int STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;

  mfv_sample_if sample_if ();
  mfv_result_if result_if ();

  most_frequent_value_finder_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  always #5 clk_i = ~clk_i;

  // Running tally of the open sequence: distinct values in ascending order.
  sample_t      tally_values[$];
  int           tally_counts[$];
  int           samples_held;
  logic         dropped_seen;
  mode_result_t pending_modes[$];
  mode_result_t oldest_mode;

  int mismatches;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  function automatic void tally_sample(sample_t v);
    int pos;
    pos = 0;
    if (samples_held == MAX_ITEMS) begin
      dropped_seen = 1'b1;
      return;
    end
    samples_held++;
    while (pos < tally_values.size() && tally_values[pos] < v) pos++;
    if (pos < tally_values.size() && tally_values[pos] == v) begin
      tally_counts[pos]++;
    end else begin
      tally_values.insert(pos, v);
      tally_counts.insert(pos, 1);
    end
  endfunction

  // Ascending scan with a strict comparison, so the smallest value wins a tie.
  function automatic void close_sequence();
    int           best;
    mode_result_t res;
    best = 0;
    for (int i = 1; i < tally_values.size(); i++) begin
      if (tally_counts[i] > tally_counts[best]) best = i;
    end
    res.value    = tally_values[best];
    res.count    = tally_counts[best][CNT_W-1:0];
    res.overflow = dropped_seen;
    pending_modes.push_back(res);
    tally_values.delete();
    tally_counts.delete();
    samples_held = 0;
    dropped_seen = 1'b0;
  endfunction

  // Entered and left at a falling edge; valid stays high on exit so that a
  // following beat can go out back to back.
  task automatic send_sample(input sample_t v, input logic ends_seq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_if.valid        <= 1'b1;
    sample_if.sample_value <= v;
    sample_if.is_last      <= ends_seq;
    do @(posedge clk_i); while (!sample_if.ready);
    tally_sample(v);
    if (ends_seq) close_sequence();
    @(negedge clk_i);
  endtask

  task automatic send_run(input sample_t run[$]);
    foreach (run[i]) send_sample(run[i], i == run.size() - 1);
  endtask

  task automatic send_repeated(input sample_t v, input int n, input logic ends_seq);
    for (int i = 0; i < n; i++) send_sample(v, ends_seq && i == n - 1);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic wait_for_results();
    sample_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_modes.size() != 0);
  endtask

  task automatic test_directed();
    send_run('{sample_t'(32'sh7fffffff)});
    send_run('{sample_t'(32'sh80000000)});
    send_run('{sample_t'(0)});
    // Tie between a positive and a negative value: the negative one wins.
    send_run('{sample_t'(1), sample_t'(-1), sample_t'(1), sample_t'(-1)});
    send_run('{sample_t'(32'sh7fffffff), sample_t'(32'sh80000000),
               sample_t'(32'sh7fffffff), sample_t'(32'sh80000000)});
    send_run('{sample_t'(5), sample_t'(3), sample_t'(5), sample_t'(5), sample_t'(3)});
    send_run('{sample_t'(7), sample_t'(-7), sample_t'(0)});
    send_run('{sample_t'(32'shaaaaaaaa), sample_t'(32'sh55555555),
               sample_t'(32'sh55555555)});
  endtask

  task automatic test_store_full();
    wait_for_results();
    send_repeated(sample_t'(-5), MAX_ITEMS, 1'b1);
    // Every value distinct, arriving in descending order.
    for (int i = 0; i < MAX_ITEMS; i++) begin
      send_sample(sample_t'(32000 - i * 1000), i == MAX_ITEMS - 1);
    end
    // The dropped beats would have made 1 the winner had they been kept.
    send_repeated(sample_t'(3), 33, 1'b0);
    send_repeated(sample_t'(1), 31, 1'b0);
    send_repeated(sample_t'(1), 5, 1'b1);
    // The overflow flag must not carry into the next sequence.
    send_run('{sample_t'(4)});
    wait_for_results();
  endtask

  task automatic test_random_sequences(input int n_items);
    sample_t pool[8];
    sample_t v;
    int      sent;
    int      len;
    int      pick;
    int      pool_n;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) len = $urandom_range(1, 16);
      else if (pick < 95) len = $urandom_range(17, MAX_ITEMS);
      else len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 16);
      pool_n = $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 3))
          0: pool[i] = sample_t'(int'($urandom_range(0, 20)) - 10);
          1: pool[i] = $urandom_range(0, 1) ? sample_t'(32'sh7fffffff)
                                            : sample_t'(32'sh80000000);
          default: pool[i] = sample_t'($urandom);
        endcase
      end
      for (int i = 0; i < len; i++) begin
        v = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                         : sample_t'($urandom);
        send_sample(v, i == len - 1);
      end
      sent += len;
    end
  endtask

  always @(negedge clk_i) begin
    result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_modes.size() == 0) begin
        $error("result beat with no sequence outstanding: mode_value %0d",
               result_if.mode_value);
        mismatches++;
      end else begin
        oldest_mode = pending_modes.pop_front();
        if (result_if.mode_value !== oldest_mode.value) begin
          $error("mode_value: expected %0d, got %0d", oldest_mode.value,
                 result_if.mode_value);
          mismatches++;
        end
        if (result_if.mode_count !== oldest_mode.count) begin
          $error("mode_count: expected %0d, got %0d", oldest_mode.count,
                 result_if.mode_count);
          mismatches++;
        end
        if (result_if.overflow !== oldest_mode.overflow) begin
          $error("overflow: expected %0b, got %0b", oldest_mode.overflow,
                 result_if.overflow);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni                 = 1'b0;
    sample_if.valid        = 1'b0;
    sample_if.sample_value = '0;
    sample_if.is_last      = 1'b0;
    result_if.ready        = 1'b0;
    samples_held           = 0;
    dropped_seen           = 1'b0;
    mismatches             = 0;
    quiet_cycles           = 0;
    send_idle_pct          = 33;
    recv_idle_pct          = 63;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_store_full();
    test_random_sequences(400);
    wait_for_results();
    send_idle_pct = 63;
    recv_idle_pct = 33;
    test_random_sequences(400);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sequences(410);
    wait_for_results();

    repeat (MAX_ITEMS + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mfv_pkg.sv
hw/rtl/mfv_if.sv
hw/rtl/mfv_cell.sv
hw/rtl/mfv_best.sv
hw/rtl/most_frequent_value_finder_unit.sv
tb/sv/most_frequent_value_finder_unit_tb.sv
